// File: rtl/tcce_pkg.sv
//------------------------------------------------------------------------------
// TCP client connection engine package
// Shared widths, command and flag codes, word types and descriptor builders.
//------------------------------------------------------------------------------
package tcce_pkg;

	localparam int NUM_CONNS = 2;
	localparam int CONN_W    = 1;
	localparam int RING_AW   = 14;
	localparam int MEM_AW    = CONN_W + RING_AW;
	localparam int MEM_DEPTH = NUM_CONNS << RING_AW;

	localparam logic [10:0] MAX_SEND = 11'd1400;

	localparam logic [2:0] CMD_HEADER  = 3'd0;
	localparam logic [2:0] CMD_PAYLOAD = 3'd1;
	localparam logic [2:0] CMD_CONNECT = 3'd2;
	localparam logic [2:0] CMD_SEND    = 3'd3;
	localparam logic [2:0] CMD_CLOSE   = 3'd4;
	localparam logic [2:0] CMD_TICK    = 3'd5;
	localparam logic [2:0] CMD_READ    = 3'd6;
	localparam logic [2:0] CMD_STATUS  = 3'd7;

	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_RST = 8'h04;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	localparam logic [1:0] PH_CLOSED  = 2'd0;
	localparam logic [1:0] PH_SYNSENT = 2'd1;
	localparam logic [1:0] PH_EST     = 2'd2;

	localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
	localparam logic [1:0] CFG_ISN       = 2'd1;
	localparam logic [1:0] CFG_PORT_BASE = 2'd2;

	localparam logic [15:0] RST_TIMEOUT   = 16'd500;
	localparam logic [31:0] RST_ISN       = 32'd2000;
	localparam logic [15:0] RST_PORT_BASE = 16'd40000;

	typedef struct packed {
		logic [2:0]  command;
		logic        conn_handle;
		logic [31:0] remote_ip;
		logic [15:0] remote_port;
		logic [15:0] dest_port;
		logic [31:0] seq_in;
		logic [7:0]  tcp_flags;
		logic [3:0]  data_offset;
		logic [15:0] segment_len;
		logic [7:0]  data_byte;
		logic [15:0] send_len;
	} tcce_req_t;

	typedef struct packed {
		logic        emit_segment;
		logic [7:0]  out_flags;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [15:0] out_src_port;
		logic [15:0] out_dst_port;
		logic [31:0] out_dst_ip;
		logic [10:0] out_payload_len;
		logic [1:0]  reply_value;
		logic        reply_error;
		logic [7:0]  read_data;
		logic        last;
	} tcce_rsp_t;

	typedef struct packed {
		logic [1:0]  addr;
		logic [31:0] wdata;
	} tcce_cfg_t;

	function automatic tcce_rsp_t make_seg(logic [7:0] flags, logic [31:0] seq,
			logic [31:0] ack, logic [15:0] src, logic [15:0] dst, logic [31:0] ip,
			logic [10:0] plen);
		tcce_rsp_t r;
		r = '0;
		r.emit_segment    = 1'b1;
		r.out_flags       = flags;
		r.out_seq         = seq;
		r.out_ack         = ack;
		r.out_src_port    = src;
		r.out_dst_port    = dst;
		r.out_dst_ip      = ip;
		r.out_payload_len = plen;
		return r;
	endfunction

	function automatic tcce_rsp_t make_reply(logic [1:0] value, logic err, logic [7:0] data);
		tcce_rsp_t r;
		r = '0;
		r.reply_value = value;
		r.reply_error = err;
		r.read_data   = data;
		return r;
	endfunction

endpackage

// File: rtl/tcce_if.sv
//------------------------------------------------------------------------------
// TCP client connection engine channels
// Valid/ready channels for commands, results and register writes.
//------------------------------------------------------------------------------
interface tcce_req_if;
	logic                valid;
	logic                ready;
	tcce_pkg::tcce_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcce_rsp_if;
	logic                valid;
	logic                ready;
	tcce_pkg::tcce_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tcce_cfg_if;
	logic                valid;
	logic                ready;
	tcce_pkg::tcce_cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/tcp_client_connection_engine.sv
//------------------------------------------------------------------------------
// TCP client connection engine
// Small table of outbound TCP connections with receive rings, driven by
// command and segment header words, emitting segment descriptors and replies.
//------------------------------------------------------------------------------
// Channel  Role    Word contents
// cfg      sink    register index and write data, always ready
// req      sink    one command, segment header or payload byte
// rsp      source  segment descriptor or reply, last marks end of a command
//
// A word is registered into the input stage and handled there.
// Words with no result (payload bytes, ticks) flow at one per cycle unless a
// result is waiting. Words with results hold the input stage until all their
// results (up to three) are taken; a non-empty read also awaits the ring read.
// Reset clears the connection table and sets register defaults; the ring is kept.
// A stalled result channel stalls the input once a result is waiting.
//------------------------------------------------------------------------------
module tcp_client_connection_engine (
	input  logic         clk,
	input  logic         arst_n,
	tcce_cfg_if.sink     cfg,
	tcce_req_if.sink     req,
	tcce_rsp_if.source   rsp
);

	localparam int NC = tcce_pkg::NUM_CONNS;
	localparam int CW = tcce_pkg::CONN_W;
	localparam int RW = tcce_pkg::RING_AW;
	localparam int MW = tcce_pkg::MEM_AW;

	// Configuration registers.
	logic [15:0] timeout_q;
	logic [31:0] isn_q;
	logic [15:0] port_base_q;

	// Connection table, one entry per connection.
	logic [1:0]    phase_q  [NC];
	logic [31:0]   peer_q   [NC];
	logic [15:0]   pport_q  [NC];
	logic [15:0]   own_q    [NC];
	logic [31:0]   snd_q    [NC];
	logic [31:0]   rcv_q    [NC];
	logic [31:0]   ctime_q  [NC];
	logic [RW-1:0] head_q   [NC];
	logic [RW-1:0] tail_q   [NC];

	logic [31:0]   tick_q;
	logic [15:0]   next_port_q;
	logic          pv_q;
	logic [CW-1:0] ptgt_q;
	logic [15:0]   pleft_q;

	// Input stage and result buffer.
	logic                s1_valid;
	tcce_pkg::tcce_req_t req_s1;
	tcce_pkg::tcce_rsp_t out_q [3];
	logic [1:0]          out_cnt_q;
	logic                rd_pend_q;
	tcce_pkg::tcce_rsp_t rd_word;

	// Receive ring memory.
	logic [7:0]    mem [tcce_pkg::MEM_DEPTH];
	logic [7:0]    rdata_q;
	logic          mem_we, mem_re;
	logic [MW-1:0] mem_wa, mem_ra;

	logic s1_go;

	assign s1_go     = s1_valid && (out_cnt_q == 2'd0) && !rd_pend_q;
	assign req.ready = !s1_valid || s1_go;
	assign cfg.ready = 1'b1;
	assign rsp.valid = (out_cnt_q != 2'd0);
	assign rsp.data  = out_q[0];

	// Per-entry lookups for header matching and free slot search.
	logic          found, any_free;
	logic [CW-1:0] midx, fidx, sel;

	always_comb begin
		found    = 1'b0;
		any_free = 1'b0;
		midx     = '0;
		fidx     = '0;
		for (int i = NC - 1; i >= 0; i--) begin
			if (phase_q[i] != tcce_pkg::PH_CLOSED && own_q[i] == req_s1.dest_port &&
					peer_q[i] == req_s1.remote_ip) begin
				found = 1'b1;
				midx  = CW'(i);
			end
			if (phase_q[i] == tcce_pkg::PH_CLOSED) begin
				any_free = 1'b1;
				fidx     = CW'(i);
			end
		end
	end

	// The single connection that this word touches.
	always_comb begin
		case (req_s1.command)
			tcce_pkg::CMD_HEADER:  sel = midx;
			tcce_pkg::CMD_CONNECT: sel = fidx;
			tcce_pkg::CMD_PAYLOAD: sel = ptgt_q;
			default:               sel = req_s1.conn_handle;
		endcase
	end

	logic [1:0]    cph;
	logic [31:0]   cpeer, csnd, crcv, cctime;
	logic [15:0]   cpport, cown;
	logic [RW-1:0] chead, ctail;

	assign cph    = phase_q[sel];
	assign cpeer  = peer_q[sel];
	assign cpport = pport_q[sel];
	assign cown   = own_q[sel];
	assign csnd   = snd_q[sel];
	assign crcv   = rcv_q[sel];
	assign cctime = ctime_q[sel];
	assign chead  = head_q[sel];
	assign ctail  = tail_q[sel];

	// Next values for the selected entry and global state, plus results.
	logic [1:0]          nph;
	logic [31:0]         npeer, nsnd, nrcv, nctime;
	logic [15:0]         npport, nown;
	logic [RW-1:0]       nhead, ntail;
	logic [31:0]         ntick;
	logic [15:0]         nnext_port;
	logic                npv;
	logic [CW-1:0]       nptgt;
	logic [15:0]         npleft;
	tcce_pkg::tcce_rsp_t res [3];
	logic [1:0]          nres;
	logic                rd_start;

	logic [5:0]    ihl;
	logic [15:0]   plen;
	logic          hdr_ok, data_ack;
	logic [31:0]   racc, r2, isn, age;
	logic [15:0]   np1;
	logic [10:0]   slen;
	logic [RW-1:0] nh;

	always_comb begin
		nph        = cph;
		npeer      = cpeer;
		npport     = cpport;
		nown       = cown;
		nsnd       = csnd;
		nrcv       = crcv;
		nctime     = cctime;
		nhead      = chead;
		ntail      = ctail;
		ntick      = tick_q;
		nnext_port = next_port_q;
		npv        = pv_q;
		nptgt      = ptgt_q;
		npleft     = pleft_q;
		res[0]     = '0;
		res[1]     = '0;
		res[2]     = '0;
		nres       = 2'd0;
		rd_start   = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_wa     = {sel, chead};
		mem_ra     = {sel, ctail};
		ihl        = {req_s1.data_offset, 2'b00};
		plen       = req_s1.segment_len - {10'd0, ihl};
		hdr_ok     = (req_s1.segment_len >= 16'd20) && (ihl >= 6'd20) &&
			({10'd0, ihl} <= req_s1.segment_len);
		data_ack   = (cph == tcce_pkg::PH_EST) && (plen != 16'd0);
		racc       = (data_ack && req_s1.seq_in == crcv) ? crcv + {16'd0, plen} : crcv;
		r2         = racc + 32'd1;
		isn        = isn_q + tick_q;
		np1        = next_port_q + 16'd1;
		slen       = (req_s1.send_len > {5'd0, tcce_pkg::MAX_SEND}) ? tcce_pkg::MAX_SEND :
			req_s1.send_len[10:0];
		nh         = chead + RW'(1);
		age        = tick_q - cctime;

		case (req_s1.command)
			tcce_pkg::CMD_HEADER: begin
				// Any header ends the payload of the one before it.
				npv    = 1'b0;
				npleft = 16'd0;
				if (hdr_ok && found) begin
					if ((req_s1.tcp_flags & tcce_pkg::FL_RST) != 8'd0) begin
						nph = tcce_pkg::PH_CLOSED;
					end else if (cph == tcce_pkg::PH_SYNSENT &&
							(req_s1.tcp_flags & tcce_pkg::FL_SYN) != 8'd0 &&
							(req_s1.tcp_flags & tcce_pkg::FL_ACK) != 8'd0) begin
						nrcv   = req_s1.seq_in + 32'd1;
						nph    = tcce_pkg::PH_EST;
						res[0] = tcce_pkg::make_seg(tcce_pkg::FL_ACK, csnd, nrcv, cown,
							cpport, cpeer, 11'd0);
						nres   = 2'd1;
					end else begin
						// In-order data is accepted; out-of-order data is only re-ACKed.
						if (data_ack) begin
							if (req_s1.seq_in == crcv) begin
								npv    = 1'b1;
								nptgt  = sel;
								npleft = plen;
							end
							res[0] = tcce_pkg::make_seg(tcce_pkg::FL_ACK, csnd, racc, cown,
								cpport, cpeer, 11'd0);
							nres   = 2'd1;
						end
						nrcv = racc;
						if ((req_s1.tcp_flags & tcce_pkg::FL_FIN) != 8'd0) begin
							nrcv = r2;
							nsnd = csnd + 32'd1;
							nph  = tcce_pkg::PH_CLOSED;
							if (data_ack) begin
								res[1] = tcce_pkg::make_seg(tcce_pkg::FL_ACK, csnd, r2, cown,
									cpport, cpeer, 11'd0);
								res[2] = tcce_pkg::make_seg(tcce_pkg::FL_FIN | tcce_pkg::FL_ACK,
									csnd, r2, cown, cpport, cpeer, 11'd0);
								nres   = 2'd3;
							end else begin
								res[0] = tcce_pkg::make_seg(tcce_pkg::FL_ACK, csnd, r2, cown,
									cpport, cpeer, 11'd0);
								res[1] = tcce_pkg::make_seg(tcce_pkg::FL_FIN | tcce_pkg::FL_ACK,
									csnd, r2, cown, cpport, cpeer, 11'd0);
								nres   = 2'd2;
							end
						end
					end
				end
			end
			tcce_pkg::CMD_PAYLOAD: begin
				// Bytes that would fill the ring completely are dropped.
				if (pv_q && pleft_q != 16'd0) begin
					npleft = pleft_q - 16'd1;
					if (nh != ctail) begin
						mem_we = 1'b1;
						nhead  = nh;
					end
				end
			end
			tcce_pkg::CMD_CONNECT: begin
				if (!any_free) begin
					res[0] = tcce_pkg::make_reply(2'd0, 1'b1, 8'd0);
				end else begin
					if (pv_q && ptgt_q == sel) begin
						npv    = 1'b0;
						npleft = 16'd0;
					end
					nhead      = '0;
					ntail      = '0;
					npeer      = req_s1.remote_ip;
					npport     = req_s1.remote_port;
					nown       = next_port_q;
					nnext_port = (np1 < port_base_q) ? port_base_q : np1;
					nrcv       = 32'd0;
					nsnd       = isn + 32'd1;
					nph        = tcce_pkg::PH_SYNSENT;
					nctime     = tick_q;
					res[0]     = tcce_pkg::make_seg(tcce_pkg::FL_SYN, isn, 32'd0,
						next_port_q, req_s1.remote_port, req_s1.remote_ip, 11'd0);
					res[0].reply_value = 2'(sel);
				end
				nres = 2'd1;
			end
			tcce_pkg::CMD_SEND: begin
				if (cph != tcce_pkg::PH_EST) begin
					res[0] = tcce_pkg::make_reply(2'd0, 1'b1, 8'd0);
				end else begin
					res[0] = tcce_pkg::make_seg(tcce_pkg::FL_PSH | tcce_pkg::FL_ACK, csnd,
						crcv, cown, cpport, cpeer, slen);
					nsnd   = csnd + {21'd0, slen};
				end
				nres = 2'd1;
			end
			tcce_pkg::CMD_CLOSE: begin
				if (cph == tcce_pkg::PH_EST) begin
					res[0] = tcce_pkg::make_seg(tcce_pkg::FL_FIN | tcce_pkg::FL_ACK, csnd,
						crcv, cown, cpport, cpeer, 11'd0);
					nsnd   = csnd + 32'd1;
					nres   = 2'd1;
				end
				nph = tcce_pkg::PH_CLOSED;
			end
			tcce_pkg::CMD_TICK: begin
				ntick = tick_q + 32'd1;
			end
			tcce_pkg::CMD_READ: begin
				// A non-empty read fetches its byte through the registered read port and replies from it.
				if (ctail == chead) begin
					res[0] = tcce_pkg::make_reply(2'd0, 1'b1, 8'd0);
					nres   = 2'd1;
				end else begin
					mem_re   = 1'b1;
					rd_start = 1'b1;
					ntail    = ctail + RW'(1);
				end
			end
			default: begin
				// Status closes a connect attempt that has waited too long.
				if (cph == tcce_pkg::PH_SYNSENT && age > {16'd0, timeout_q}) begin
					nph    = tcce_pkg::PH_CLOSED;
					res[0] = tcce_pkg::make_reply(2'd0, 1'b0, 8'd0);
				end else begin
					res[0] = tcce_pkg::make_reply((cph <= tcce_pkg::PH_EST) ? cph : 2'd0,
						1'b0, 8'd0);
				end
				nres = 2'd1;
			end
		endcase

		case (nres)
			2'd1:    res[0].last = 1'b1;
			2'd2:    res[1].last = 1'b1;
			2'd3:    res[2].last = 1'b1;
			default: ;
		endcase
	end

	// The reply of a non-empty read, built from the fetched ring byte.
	always_comb begin
		rd_word      = tcce_pkg::make_reply(2'd0, 1'b0, rdata_q);
		rd_word.last = 1'b1;
	end

	// Ring memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (s1_go && mem_we) begin
			mem[mem_wa] <= req_s1.data_byte;
		end
		if (s1_go && mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= tcce_pkg::RST_TIMEOUT;
			isn_q       <= tcce_pkg::RST_ISN;
			port_base_q <= tcce_pkg::RST_PORT_BASE;
			for (int i = 0; i < NC; i++) begin
				phase_q[i] <= tcce_pkg::PH_CLOSED;
				peer_q[i]  <= '0;
				pport_q[i] <= '0;
				own_q[i]   <= '0;
				snd_q[i]   <= '0;
				rcv_q[i]   <= '0;
				ctime_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
			tick_q      <= '0;
			next_port_q <= tcce_pkg::RST_PORT_BASE;
			pv_q        <= 1'b0;
			ptgt_q      <= '0;
			pleft_q     <= '0;
			s1_valid    <= 1'b0;
			out_cnt_q   <= 2'd0;
			rd_pend_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				case (cfg.data.addr)
					tcce_pkg::CFG_TIMEOUT:   timeout_q   <= cfg.data.wdata[15:0];
					tcce_pkg::CFG_ISN:       isn_q       <= cfg.data.wdata;
					tcce_pkg::CFG_PORT_BASE: port_base_q <= cfg.data.wdata[15:0];
					default: ;
				endcase
			end

			if (req.valid && req.ready) begin
				s1_valid <= 1'b1;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end

			if (s1_go) begin
				phase_q[sel] <= nph;
				peer_q[sel]  <= npeer;
				pport_q[sel] <= npport;
				own_q[sel]   <= nown;
				snd_q[sel]   <= nsnd;
				rcv_q[sel]   <= nrcv;
				ctime_q[sel] <= nctime;
				head_q[sel]  <= nhead;
				tail_q[sel]  <= ntail;
				tick_q       <= ntick;
				next_port_q  <= nnext_port;
				pv_q         <= npv;
				ptgt_q       <= nptgt;
				pleft_q      <= npleft;
			end

			rd_pend_q <= s1_go && rd_start;

			// The result buffer is loaded only when empty and drains from entry 0.
			if (s1_go && nres != 2'd0) begin
				out_q[0]  <= res[0];
				out_q[1]  <= res[1];
				out_q[2]  <= res[2];
				out_cnt_q <= nres;
			end else if (rd_pend_q) begin
				out_q[0]  <= rd_word;
				out_cnt_q <= 2'd1;
			end else if (rsp.valid && rsp.ready) begin
				out_q[0]  <= out_q[1];
				out_q[1]  <= out_q[2];
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/tcce_checker.sv
//------------------------------------------------------------------------------
// TCP client connection engine checker
// Port-level assertions, attached to the top level by a bind statement.
//------------------------------------------------------------------------------
module tcce_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input tcce_pkg::tcce_rsp_t rsp_data,
	input logic                cfg_ready
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word dropped or changed while stalled");

	a_seg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.emit_segment |-> rsp_data.out_flags == 8'd0 &&
		rsp_data.out_seq == 32'd0 && rsp_data.out_payload_len == 11'd0)
		else $error("reply carries segment fields");

	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.emit_segment && rsp_data.out_flags != tcce_pkg::FL_SYN |->
		rsp_data.reply_value == 2'd0 && !rsp_data.reply_error && rsp_data.read_data == 8'd0)
		else $error("segment carries reply fields");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind tcp_client_connection_engine tcce_checker u_tcce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data),
	.cfg_ready (cfg.ready)
);
